[rtl/rpp_pkg.sv]
package rpp_pkg;

    localparam int BIN_COUNT   = 1024;
    localparam int BIN_BITS    = 10;
    localparam int COORD_BITS  = 18;
    localparam int RANGE_BITS  = 18;
    localparam int RING_BITS   = 4;
    localparam int STEPS       = 20;
    localparam int STEP_BITS   = 5;
    localparam int SCALE_SHIFT = 30;
    localparam int CW          = COORD_BITS + SCALE_SHIFT + 3;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int Q_DEPTH     = 2;
    localparam logic [RANGE_BITS-1:0] EMPTY_MARK = '1;

    localparam logic CFG_FIRST_RING  = 1'b0;
    localparam logic CFG_SECOND_RING = 1'b1;
    localparam logic [RING_BITS-1:0] FIRST_RING_RESET  = 4'd14;
    localparam logic [RING_BITS-1:0] SECOND_RING_RESET = 4'd1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_RMW  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        t_op                          op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [BIN_BITS-1:0]          rbin;
    } t_cmd;

    function automatic logic [31:0] turn_atan(input logic [STEP_BITS-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/ring_points_to_polar_min_range_bins_unit.sv]
// Path of an item: queue pickup, a loop of 20 CORDIC steps with the root bits,
// then a bin read-modify-write and, for a read, the output state.
// The back end takes no new item until the last is done, a read until its output is taken;
// points of other rings are dropped at the input and cost no back end time.
// Reset: synchronous active low; rings go to 14 and 1, then a clearing pass over
// all 1024 bins empties them before the back end takes items.
module ring_points_to_polar_min_range_bins_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // x[17:0] y[35:18] ring[39:36] read_bin[49:40]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // bin_number[9:0] min_range[27:10] bin_empty[28]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import rpp_pkg::*;

    logic q_valid, q_ready;
    t_cmd q_cmd;
    logic [BIN_BITS-1:0] bin;
    logic [RANGE_BITS-1:0] rng;
    logic emp;

    assign o_cfg_ready = 1'b1;

    rpp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser),
        .i_x(s_axis_tdata[17:0]), .i_y(s_axis_tdata[35:18]),
        .i_ring(s_axis_tdata[39:36]), .i_rbin(s_axis_tdata[49:40]),
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_cmd(q_cmd)
    );

    rpp_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_bin(bin), .o_range(rng), .o_empty(emp)
    );

    assign m_axis_tdata = {3'b0, emp, rng, bin};
endmodule

[rtl/rpp_front.sv]
module rpp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic signed [rpp_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [rpp_pkg::COORD_BITS-1:0] i_y,
    input  logic [rpp_pkg::RING_BITS-1:0]     i_ring,
    input  logic [rpp_pkg::BIN_BITS-1:0]      i_rbin,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [rpp_pkg::RING_BITS-1:0]     i_cfg_data,
    output logic                              o_q_valid,
    input  logic                              i_q_ready,
    output rpp_pkg::t_cmd                     o_q_cmd
);
    import rpp_pkg::*;

    logic [RING_BITS-1:0] r_ring0, r_ring1;
    t_cmd r_mem [Q_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic keep, push, pop;
    t_cmd cmd;

    assign keep = (t_op'(i_op) == OP_READ) || (i_ring == r_ring0) || (i_ring == r_ring1);
    assign o_ready = (r_cnt != 2'(Q_DEPTH));
    assign push = i_valid && o_ready && keep;
    assign pop = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_mem[r_rp];

    always_comb begin
        cmd.op = t_op'(i_op);
        cmd.x = i_x;
        cmd.y = i_y;
        cmd.rbin = i_rbin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring0 <= FIRST_RING_RESET;
            r_ring1 <= SECOND_RING_RESET;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FIRST_RING) r_ring0 <= i_cfg_data;
                else r_ring1 <= i_cfg_data;
            end
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= cmd;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(Q_DEPTH))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
endmodule

[rtl/rpp_back.sv]
module rpp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  rpp_pkg::t_cmd                 i_q_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rpp_pkg::BIN_BITS-1:0]  o_bin,
    output logic [rpp_pkg::RANGE_BITS-1:0] o_range,
    output logic                          o_empty
);
    import rpp_pkg::*;

    t_state r_state, n_state;
    t_cmd r_cmd;
    logic signed [CW-1:0] r_cx, r_cy;
    logic [31:0] r_acc;
    logic [STEP_BITS-1:0] r_i;
    logic [SQ_BITS-1:0] r_rem, r_root;
    logic [SQ_BITS-1:0] r_sq;
    logic r_origin;
    logic [BIN_BITS-1:0] r_addr;
    logic [RANGE_BITS-1:0] r_rd;
    logic r_rd_empty;
    logic [RANGE_BITS:0] r_mem [BIN_COUNT];
    logic [BIN_BITS:0] r_clr;
    logic r_rmw2;

    logic [RANGE_BITS:0] rd_ent;
    logic signed [CW-1:0] xs, ys;
    logic [SQ_BITS-1:0] sq_bit, trial;
    logic [31:0] acc_r;
    logic [BIN_BITS-1:0] bin;
    logic [RANGE_BITS-1:0] rad;
    logic [COORD_BITS-1:0] ax, ay;
    logic clearing;

    assign clearing = !r_clr[BIN_BITS];
    assign o_q_ready = (r_state == ST_IDLE) && !clearing;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid && !clearing) n_state = ST_RUN;
            ST_RUN:  if (r_i == 5'(STEPS)) n_state = ST_RMW;
            ST_RMW:  if (r_rmw2) n_state = (r_cmd.op == OP_READ) ? ST_OUT : ST_IDLE;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid = (r_state == ST_OUT);
        o_bin = r_cmd.rbin;
        o_range = r_rd;
        o_empty = r_rd_empty;
    end

    always_comb begin
        xs = r_cx >>> r_i;
        ys = r_cy >>> r_i;
        sq_bit = (r_i >= 5'd1 && r_i <= 5'(SQ_BITS / 2))
               ? (SQ_BITS'(1) << (6'(SQ_BITS) - {r_i, 1'b0})) : '0;
        trial = r_sq | sq_bit;
        acc_r = (r_acc + 32'd2048) & ~32'd4095;
        bin = r_origin ? '0 : acc_r[31 -: BIN_BITS];
        rad = (r_root > SQ_BITS'(EMPTY_MARK)) ? EMPTY_MARK : r_root[RANGE_BITS-1:0];
        ax = r_cmd.x[COORD_BITS-1] ? -r_cmd.x : r_cmd.x;
        ay = r_cmd.y[COORD_BITS-1] ? -r_cmd.y : r_cmd.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        rd_ent <= r_mem[r_addr];
        if (clearing) r_mem[r_clr[BIN_BITS-1:0]] <= {1'b0, EMPTY_MARK};
        else if (r_state == ST_RMW && r_rmw2) begin
            if (r_cmd.op == OP_READ) r_mem[r_addr] <= {1'b0, EMPTY_MARK};
            else if (!rd_ent[RANGE_BITS] || rad < rd_ent[RANGE_BITS-1:0])
                r_mem[r_addr] <= {1'b1, rad};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rmw2 <= (r_state == ST_RMW) && !r_rmw2;
        unique case (r_state)
            ST_IDLE: begin
                r_cmd <= i_q_cmd;
                r_i <= '0;
                r_origin <= (i_q_cmd.x == 0) && (i_q_cmd.y == 0);
                if (i_q_cmd.x < 0) begin
                    r_cx <= CW'(-(COORD_BITS+1)'(i_q_cmd.x)) <<< SCALE_SHIFT;
                    r_cy <= CW'(-(COORD_BITS+1)'(i_q_cmd.y)) <<< SCALE_SHIFT;
                    r_acc <= 32'h8000_0000;
                end else begin
                    r_cx <= CW'(i_q_cmd.x) <<< SCALE_SHIFT;
                    r_cy <= CW'(i_q_cmd.y) <<< SCALE_SHIFT;
                    r_acc <= '0;
                end
                r_rem <= '0;
                r_root <= '0;
                r_sq <= '0;
            end
            ST_RUN: begin
                if (r_i == 5'd0) begin
                    r_rem <= {{COORD_BITS{1'b0}}, ax} * {{COORD_BITS{1'b0}}, ax}
                           + {{COORD_BITS{1'b0}}, ay} * {{COORD_BITS{1'b0}}, ay};
                end
                if (r_i < 5'(STEPS)) begin
                    r_i <= r_i + 5'd1;
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_acc <= r_acc + turn_atan(r_i);
                    end else begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_acc <= r_acc - turn_atan(r_i);
                    end
                end
                r_addr <= (r_cmd.op == OP_READ) ? r_cmd.rbin : bin;
            end
            ST_RMW: begin
                r_rd <= rd_ent[RANGE_BITS-1:0];
                r_rd_empty <= !rd_ent[RANGE_BITS];
            end
            default: ;
        endcase
        // root: one result bit per cycle, steps 1..18 of the run
        if (r_state == ST_RUN && sq_bit != '0) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_sq <= (r_sq >> 1) | sq_bit;
            end else begin
                r_sq <= r_sq >> 1;
            end
        end
        if (r_state == ST_RUN) r_root <= r_sq;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_q_ready) else $error("accept during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_i <= 5'(STEPS)) else $error("step overrun");
endmodule

[test/tb_ring_points_to_polar_min_range_bins_unit.sv]
`timescale 1ns / 1ps

module tb_ring_points_to_polar_min_range_bins_unit;
    import rpp_pkg::*;

    localparam logic [31:0] TURN_ATAN [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
    };

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin;
        logic [RANGE_BITS-1:0] range;
        logic                  empty;
    } t_bin_read;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [3:0]  i_cfg_data = '0;

    ring_points_to_polar_min_range_bins_unit dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [RANGE_BITS-1:0] bin_min [BIN_COUNT];
    logic                  bin_hit [BIN_COUNT];
    logic [3:0]            ring_a = 4'd14;
    logic [3:0]            ring_b = 4'd1;
    t_bin_read             pending_reads [$];
    int                    mismatches = 0;
    int                    reads_done = 0;
    int                    inserts_done = 0;
    int                    burst_left = 0;
    bit                    stall_on = 1'b0;

    function automatic logic [BIN_BITS-1:0] azimuth_bin(logic signed [COORD_BITS-1:0] px,
                                                        logic signed [COORD_BITS-1:0] py);
        longint cx;
        longint cy;
        longint nx;
        logic [31:0] ang;
        cx = px;
        cy = py;
        ang = '0;
        if (cx == 0 && cy == 0) return '0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            ang = 32'h8000_0000;
        end
        cx = cx <<< SCALE_SHIFT;
        cy = cy <<< SCALE_SHIFT;
        for (int i = 0; i < STEPS; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                ang = ang + TURN_ATAN[i];
            end else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                ang = ang - TURN_ATAN[i];
            end
            cx = nx;
        end
        ang = (ang + 32'd2048) & ~32'd4095;
        return ang[31:32-BIN_BITS];
    endfunction

    function automatic longint radius_mm(logic signed [COORD_BITS-1:0] px,
                                         logic signed [COORD_BITS-1:0] py);
        longint sq;
        longint lo;
        longint hi;
        longint mid;
        sq = longint'(px) * px + longint'(py) * py;
        lo = 0;
        hi = 1 << 20;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= sq) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    task automatic predict_item(t_op op, logic signed [COORD_BITS-1:0] px,
                                logic signed [COORD_BITS-1:0] py, logic [3:0] ring,
                                logic [BIN_BITS-1:0] rb);
        longint r;
        logic [BIN_BITS-1:0] b;
        t_bin_read e;
        if (op == OP_INSERT) begin
            if (ring != ring_a && ring != ring_b) return;
            r = radius_mm(px, py);
            if (r > EMPTY_MARK) r = EMPTY_MARK;
            b = azimuth_bin(px, py);
            if (!bin_hit[b] || r[RANGE_BITS-1:0] < bin_min[b]) begin
                bin_min[b] = r[RANGE_BITS-1:0];
                bin_hit[b] = 1'b1;
            end
        end else begin
            e.bin = rb;
            e.range = bin_min[rb];
            e.empty = !bin_hit[rb];
            pending_reads.push_back(e);
            bin_min[rb] = EMPTY_MARK;
            bin_hit[rb] = 1'b0;
        end
    endtask

    task automatic send_item(t_op op, logic signed [COORD_BITS-1:0] px,
                             logic signed [COORD_BITS-1:0] py, logic [3:0] ring,
                             logic [BIN_BITS-1:0] rb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, rb, ring, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(op, px, py, ring, rb);
        if (op == OP_INSERT) inserts_done++;
    endtask

    task automatic insert_point(int px, int py, logic [3:0] ring);
        send_item(OP_INSERT, COORD_BITS'(px), COORD_BITS'(py), ring, '0);
    endtask

    task automatic read_bin(int rb);
        send_item(OP_READ, '0, '0, '0, BIN_BITS'(rb));
    endtask

    task automatic drain_reads();
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_ring(logic idx, logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FIRST_RING) ring_a = val;
        else ring_b = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %h", m_axis_tdata);
                end else begin
                    t_bin_read e;
                    e = pending_reads.pop_front();
                    if (m_axis_tdata[9:0] !== e.bin || m_axis_tdata[27:10] !== e.range
                        || m_axis_tdata[28] !== e.empty) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch bin exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.bin, e.range, e.empty, m_axis_tdata[9:0],
                                     m_axis_tdata[27:10], m_axis_tdata[28]);
                    end
                    reads_done++;
                end
            end
            if ($urandom_range(0, 63) == 0) stall_on <= !stall_on;
            m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    task automatic test_directed();
        insert_point(0, 0, ring_a);
        read_bin(0);
        read_bin(0);
        insert_point(131071, 131071, ring_b);
        insert_point(-131072, -131072, ring_a);
        insert_point(-131072, 0, ring_a);
        insert_point(0, -131072, ring_b);
        insert_point(131071, 0, ring_a);
        insert_point(0, 131071, ring_a);
        insert_point(-1, -1, ring_b);
        insert_point(1000, 5, 4'd7);
        insert_point(3000, 4, ring_a);
        insert_point(300, 1, ring_a);
        read_bin(0);
        read_bin(128);
        read_bin(384);
        read_bin(512);
        read_bin(640);
        read_bin(768);
        read_bin(896);
        read_bin(1023);
        read_bin(1);
        drain_reads();
    endtask

    task automatic test_random(int n);
        int k;
        int sh;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                read_bin($urandom_range(0, 1023));
            end else begin
                sh = $urandom_range(0, 17);
                insert_point($signed($urandom()) >>> (14 + sh), $signed($urandom()) >>> (14 + sh),
                             $urandom_range(0, 4) == 0 ? RING_BITS'($urandom_range(0, 15))
                             : ($urandom_range(0, 1) ? ring_a : ring_b));
            end
        end
        drain_reads();
    endtask

    task automatic test_ring_settings();
        write_ring(CFG_FIRST_RING, 4'd0);
        write_ring(CFG_SECOND_RING, 4'd15);
        test_random(300);
        write_ring(CFG_FIRST_RING, 4'd15);
        write_ring(CFG_SECOND_RING, 4'd15);
        test_random(300);
        write_ring(CFG_FIRST_RING, 4'd5);
        write_ring(CFG_SECOND_RING, 4'd9);
        test_random(300);
    endtask

    task automatic test_full_drain();
        for (int b = 0; b < BIN_COUNT; b += 37) read_bin(b);
        drain_reads();
    endtask

    initial begin
        for (int b = 0; b < BIN_COUNT; b++) begin
            bin_min[b] = EMPTY_MARK;
            bin_hit[b] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300);
        test_ring_settings();
        test_full_drain();
        $display("covered %0d inserts and %0d bin reads over four ring settings",
                 inserts_done, reads_done);
        if (mismatches == 0 && pending_reads.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
rtl/rpp_pkg.sv
rtl/rpp_front.sv
rtl/rpp_back.sv
rtl/ring_points_to_polar_min_range_bins_unit.sv
test/tb_ring_points_to_polar_min_range_bins_unit.sv
